/* sv/vpfp_pkg.sv */
// ----------------------------------------------------------------------------
// vpfp_pkg
// Shared types, step codes, error codes and limits of the varint packet
// field parser.
// ----------------------------------------------------------------------------
package vpfp_pkg;

  // parse steps, which double as result tags
  localparam logic [4:0] ST_LENGTH        = 5'd0;
  localparam logic [4:0] ST_ID            = 5'd1;
  localparam logic [4:0] ST_HS_VERSION    = 5'd2;
  localparam logic [4:0] ST_HS_ADDR_LEN   = 5'd3;
  localparam logic [4:0] ST_HS_ADDR_BYTE  = 5'd4;
  localparam logic [4:0] ST_HS_PORT       = 5'd5;
  localparam logic [4:0] ST_HS_NEXT       = 5'd6;
  localparam logic [4:0] ST_PING          = 5'd7;
  localparam logic [4:0] ST_LOGIN_LEN     = 5'd8;
  localparam logic [4:0] ST_LOGIN_BYTE    = 5'd9;
  localparam logic [4:0] ST_CS_LOC_LEN    = 5'd10;
  localparam logic [4:0] ST_CS_LOC_BYTE   = 5'd11;
  localparam logic [4:0] ST_CS_VIEW       = 5'd12;
  localparam logic [4:0] ST_CS_CHAT       = 5'd13;
  localparam logic [4:0] ST_CS_COLORS     = 5'd14;
  localparam logic [4:0] ST_CS_SKIN       = 5'd15;
  localparam logic [4:0] ST_CS_HAND       = 5'd16;
  localparam logic [4:0] ST_CS_FILTER     = 5'd17;
  localparam logic [4:0] ST_PL_CHAN_LEN   = 5'd18;
  localparam logic [4:0] ST_PL_CHAN_BYTE  = 5'd19;
  localparam logic [4:0] ST_PL_DATA       = 5'd20;

  // packet kinds
  localparam logic [2:0] KIND_HANDSHAKE   = 3'd0;
  localparam logic [2:0] KIND_STATUS      = 3'd1;
  localparam logic [2:0] KIND_PING        = 3'd2;
  localparam logic [2:0] KIND_LOGIN       = 3'd3;
  localparam logic [2:0] KIND_SETTINGS    = 3'd4;
  localparam logic [2:0] KIND_PLUGIN      = 3'd5;

  // packet ids expected for each kind
  localparam logic [31:0] ID_HANDSHAKE    = 32'h00;
  localparam logic [31:0] ID_STATUS       = 32'h00;
  localparam logic [31:0] ID_PING         = 32'h01;
  localparam logic [31:0] ID_LOGIN        = 32'h00;
  localparam logic [31:0] ID_SETTINGS     = 32'h05;
  localparam logic [31:0] ID_PLUGIN       = 32'h0a;

  // error codes
  localparam logic [2:0] ERR_NONE         = 3'd0;
  localparam logic [2:0] ERR_VARINT_LONG  = 3'd1;
  localparam logic [2:0] ERR_WRONG_ID     = 3'd2;
  localparam logic [2:0] ERR_BAD_STRLEN   = 3'd3;
  localparam logic [2:0] ERR_LEN_SHORT    = 3'd4;

  // string limits and field sizes
  localparam logic [31:0] LIMIT_ADDR      = 32'd255;
  localparam logic [31:0] LIMIT_NAME      = 32'd16;
  localparam logic [31:0] LIMIT_CHANNEL   = 32'd32767;
  localparam logic [3:0]  VARINT_MAX_CONT = 4'd4;
  localparam logic [3:0]  USHORT_BYTES    = 4'd2;
  localparam logic [3:0]  LONG_BYTES      = 4'd8;

  // running parse state
  typedef struct packed {
    logic [4:0]  step;
    logic [3:0]  byte_cnt;
    logic [63:0] acc;
    logic [14:0] str_rem;
    logic [31:0] decl_len;
    logic [31:0] consumed;
    logic        halted;
  } parse_state_t;

  // one result item
  typedef struct packed {
    logic [4:0]  tag;
    logic [63:0] value;
    logic        last;
    logic [2:0]  err;
  } result_t;

  function automatic logic [63:0] sext32(input logic [31:0] v);
    return {{32{v[31]}}, v};
  endfunction

endpackage

/* sv/vpfp_if.sv */
// ----------------------------------------------------------------------------
// vpfp_in_if / vpfp_out_if
// Valid/ready channels for received bytes and for parsed field results.
// ----------------------------------------------------------------------------
interface vpfp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

interface vpfp_out_if;
  logic               valid;
  logic               ready;
  logic [4:0]         field_tag;
  logic signed [63:0] field_value;
  logic               last_of_packet;
  logic [2:0]         error_code;

  modport source (output valid, output field_tag, output field_value,
                  output last_of_packet, output error_code, input ready);
  modport sink   (input valid, input field_tag, input field_value,
                  input last_of_packet, input error_code, output ready);
endinterface

/* sv/vpfp_in_stage.sv */
// ----------------------------------------------------------------------------
// vpfp_in_stage
// Input register: holds one received byte until the parse stage takes it.
// ----------------------------------------------------------------------------
module vpfp_in_stage
  import vpfp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  vpfp_in_if.sink    in_bus,
  input  logic       take,
  output logic       byte_valid,
  output logic [7:0] byte_data
);

  logic       valid_r;
  logic [7:0] byte_r;

  // room when empty or when the held byte leaves this cycle
  assign in_bus.ready = !valid_r || take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_bus.valid && in_bus.ready) begin
      valid_r <= 1'b1;
    end else if (take) begin
      valid_r <= 1'b0;
    end
  end

  // payload capture
  always_ff @(posedge clk) begin
    if (in_bus.valid && in_bus.ready) begin
      byte_r <= in_bus.data_byte;
    end
  end

  assign byte_valid = valid_r;
  assign byte_data  = byte_r;

endmodule

/* sv/vpfp_parse.sv */
// ----------------------------------------------------------------------------
// vpfp_parse
// Next-state and result logic for one received byte.
// ----------------------------------------------------------------------------
module vpfp_parse
  import vpfp_pkg::*;
(
  input  parse_state_t st,
  input  logic [7:0]   data_byte,
  input  logic [2:0]   packet_kind,
  output parse_state_t st_nxt,
  output logic         res_valid,
  output result_t      res
);

  function automatic logic [31:0] kind_id(input logic [2:0] k);
    logic [31:0] id;
    case (k)
      KIND_HANDSHAKE: id = ID_HANDSHAKE;
      KIND_STATUS:    id = ID_STATUS;
      KIND_PING:      id = ID_PING;
      KIND_LOGIN:     id = ID_LOGIN;
      KIND_SETTINGS:  id = ID_SETTINGS;
      default:        id = ID_PLUGIN;
    endcase
    return id;
  endfunction

  function automatic logic [4:0] kind_first_step(input logic [2:0] k);
    logic [4:0] s;
    case (k)
      KIND_HANDSHAKE: s = ST_HS_VERSION;
      KIND_PING:      s = ST_PING;
      KIND_LOGIN:     s = ST_LOGIN_LEN;
      KIND_SETTINGS:  s = ST_CS_LOC_LEN;
      KIND_PLUGIN:    s = ST_PL_CHAN_LEN;
      default:        s = ST_LENGTH;
    endcase
    return s;
  endfunction

  logic [4:0]         step_eff;
  logic [31:0]        consumed_inc;
  logic [5:0]         vshamt;
  logic [31:0]        vpart;
  logic [31:0]        vacc;
  logic [31:0]        limit;
  logic [14:0]        rem_dec;
  logic [63:0]        fix_acc;
  logic [3:0]         fix_cnt;
  logic [3:0]         fix_need;
  logic signed [32:0] decl_s;
  logic signed [32:0] used_s;
  logic               dlv_req;
  logic [4:0]         dlv_step;
  logic [63:0]        dlv_val;
  logic               fail_req;
  logic [2:0]         fail_code;

  // an out-of-range step restarts at the packet length
  assign step_eff     = (st.step > ST_PL_DATA) ? ST_LENGTH : st.step;
  assign consumed_inc = st.consumed + 32'd1;

  // varint group: shift by 7 * byte count
  assign vshamt = {st.byte_cnt[2:0], 3'b000} - {3'b000, st.byte_cnt[2:0]};
  assign vpart  = {25'd0, data_byte[6:0]} << vshamt;
  assign vacc   = st.acc[31:0] | vpart;

  // string length limit of the current step
  always_comb begin
    case (step_eff)
      ST_HS_ADDR_LEN: limit = LIMIT_ADDR;
      ST_PL_CHAN_LEN: limit = LIMIT_CHANNEL;
      default:        limit = LIMIT_NAME;
    endcase
  end

  assign rem_dec  = (st.str_rem != 15'd0) ? st.str_rem - 15'd1 : st.str_rem;

  // big-endian fixed fields
  assign fix_acc  = {st.acc[55:0], data_byte};
  assign fix_cnt  = st.byte_cnt + 4'd1;
  assign fix_need = (step_eff == ST_HS_PORT) ? USHORT_BYTES : LONG_BYTES;

  // declared length against bytes seen after the length varint
  assign decl_s = $signed({st.decl_len[31], st.decl_len});
  assign used_s = $signed({1'b0, consumed_inc});

  always_comb begin
    st_nxt    = st;
    res       = '0;
    res_valid = 1'b0;
    dlv_req   = 1'b0;
    dlv_step  = step_eff;
    dlv_val   = '0;
    fail_req  = 1'b0;
    fail_code = ERR_NONE;
    res.tag   = step_eff;

    if (!st.halted) begin
      st_nxt.step = step_eff;
      if (step_eff != ST_LENGTH) begin
        st_nxt.consumed = consumed_inc;
      end

      case (step_eff)
        // varint fields
        ST_LENGTH, ST_ID, ST_HS_VERSION, ST_HS_ADDR_LEN, ST_HS_NEXT,
        ST_LOGIN_LEN, ST_CS_LOC_LEN, ST_CS_CHAT, ST_CS_HAND, ST_PL_CHAN_LEN: begin
          if (data_byte[7]) begin
            if (st.byte_cnt >= VARINT_MAX_CONT) begin
              fail_req  = 1'b1;
              fail_code = ERR_VARINT_LONG;
            end else begin
              st_nxt.byte_cnt = st.byte_cnt + 4'd1;
              st_nxt.acc      = {st.acc[63:32], vacc};
            end
          end else begin
            st_nxt.acc      = '0;
            st_nxt.byte_cnt = '0;
            case (step_eff)
              ST_LENGTH: begin
                st_nxt.decl_len = vacc;
                st_nxt.consumed = '0;
                st_nxt.step     = ST_ID;
                res_valid       = 1'b1;
                res.value       = sext32(vacc);
              end
              ST_ID: begin
                if (packet_kind > KIND_PLUGIN || vacc != kind_id(packet_kind)) begin
                  fail_req  = 1'b1;
                  fail_code = ERR_WRONG_ID;
                end else if (packet_kind == KIND_STATUS) begin
                  st_nxt.step = ST_LENGTH;
                  res_valid   = 1'b1;
                  res.value   = sext32(vacc);
                  res.last    = 1'b1;
                end else begin
                  st_nxt.step = kind_first_step(packet_kind);
                  res_valid   = 1'b1;
                  res.value   = sext32(vacc);
                end
              end
              ST_HS_ADDR_LEN, ST_LOGIN_LEN, ST_CS_LOC_LEN, ST_PL_CHAN_LEN: begin
                if (vacc[31] || vacc > limit) begin
                  fail_req  = 1'b1;
                  fail_code = ERR_BAD_STRLEN;
                end else begin
                  st_nxt.str_rem = vacc[14:0];
                  if (vacc == 32'd0) begin
                    // empty string completes its byte field at once
                    dlv_req  = 1'b1;
                    dlv_step = step_eff + 5'd1;
                  end else begin
                    st_nxt.step = step_eff + 5'd1;
                    res_valid   = 1'b1;
                    res.value   = {32'd0, vacc};
                  end
                end
              end
              default: begin
                dlv_req = 1'b1;
                dlv_val = sext32(vacc);
              end
            endcase
          end
        end

        // string bytes
        ST_HS_ADDR_BYTE, ST_LOGIN_BYTE, ST_CS_LOC_BYTE, ST_PL_CHAN_BYTE: begin
          st_nxt.str_rem = rem_dec;
          if (rem_dec == 15'd0) begin
            dlv_req = 1'b1;
            dlv_val = {56'd0, data_byte};
          end else begin
            res_valid = 1'b1;
            res.value = {56'd0, data_byte};
          end
        end

        // ushort and long
        ST_HS_PORT, ST_PING: begin
          if (fix_cnt >= fix_need) begin
            dlv_req         = 1'b1;
            dlv_val         = fix_acc;
            st_nxt.acc      = '0;
            st_nxt.byte_cnt = '0;
          end else begin
            st_nxt.acc      = fix_acc;
            st_nxt.byte_cnt = fix_cnt;
          end
        end

        // plain bytes
        ST_CS_VIEW, ST_CS_SKIN: begin
          dlv_req = 1'b1;
          dlv_val = {56'd0, data_byte};
        end

        // bools
        ST_CS_COLORS, ST_CS_FILTER: begin
          dlv_req = 1'b1;
          dlv_val = {63'd0, (data_byte != 8'd0)};
        end

        // plugin data runs to the declared length
        default: begin
          res_valid = 1'b1;
          res.tag   = ST_PL_DATA;
          res.value = {56'd0, data_byte};
          if (used_s >= decl_s) begin
            res.last    = 1'b1;
            st_nxt.step = ST_LENGTH;
          end
        end
      endcase

      // field completion
      if (dlv_req) begin
        res_valid = 1'b1;
        res.value = dlv_val;
        if (dlv_step inside {ST_HS_VERSION, ST_HS_ADDR_BYTE, ST_HS_PORT, ST_CS_LOC_BYTE,
                             ST_CS_VIEW, ST_CS_CHAT, ST_CS_COLORS, ST_CS_SKIN,
                             ST_CS_HAND}) begin
          st_nxt.step = dlv_step + 5'd1;
        end else if (dlv_step == ST_PL_CHAN_BYTE) begin
          if (decl_s < used_s) begin
            fail_req  = 1'b1;
            fail_code = ERR_LEN_SHORT;
          end else if (decl_s == used_s) begin
            st_nxt.step = ST_LENGTH;
            res.last    = 1'b1;
          end else begin
            st_nxt.step = ST_PL_DATA;
          end
        end else begin
          st_nxt.step = ST_LENGTH;
          res.last    = 1'b1;
        end
      end

      // errors stop the parser
      if (fail_req) begin
        st_nxt.halted = 1'b1;
        res_valid     = 1'b1;
        res.tag       = step_eff;
        res.value     = '0;
        res.last      = 1'b1;
        res.err       = fail_code;
      end
    end
  end

endmodule

/* sv/varint_packet_field_parser_core.sv */
// ----------------------------------------------------------------------------
// varint_packet_field_parser_core
// Parses varint length-prefixed packets of one configured kind from a byte
// stream and gives one tagged result per field, string byte or data byte.
// ----------------------------------------------------------------------------
//  channel   direction  payload                                        rule
//  in_bus    in         data_byte[7:0]                                 valid & ready
//  out_bus   out        field_tag, field_value, last_of_packet, error  valid & ready
//  cfg_wr_*  in         packet_kind[2:0]                               write when wr_en
//
//  one byte per cycle sustained while out_bus does not stall; a byte passes
//  through the input register, then the parse logic into the result register
//  rst_n is synchronous: parser at the start of a packet, kind handshake
//  a stall on out_bus holds the result; the input register takes at most one
//  more byte and then holds in_bus.ready low
//  bytes that give no result still pass through the input register
// ----------------------------------------------------------------------------
module varint_packet_field_parser_core
  import vpfp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  vpfp_in_if.sink    in_bus,
  vpfp_out_if.source out_bus,
  input  logic       cfg_wr_en,
  input  logic [2:0] cfg_wr_data
);

  logic [2:0]   kind_r;
  parse_state_t st_r;
  parse_state_t st_nxt;
  logic         out_valid_r;
  result_t      res_r;
  result_t      res;
  logic         res_valid;
  logic         byte_valid;
  logic [7:0]   byte_data;
  logic         take;

  // parse stage moves when the result register has room
  assign take = byte_valid && (!out_valid_r || out_bus.ready);

  vpfp_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_bus     (in_bus),
    .take       (take),
    .byte_valid (byte_valid),
    .byte_data  (byte_data)
  );

  vpfp_parse u_parse (
    .st          (st_r),
    .data_byte   (byte_data),
    .packet_kind (kind_r),
    .st_nxt      (st_nxt),
    .res_valid   (res_valid),
    .res         (res)
  );

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r <= KIND_HANDSHAKE;
    end else if (cfg_wr_en) begin
      kind_r <= cfg_wr_data;
    end
  end

  // parse state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (take) begin
      st_r <= st_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (take && res_valid) begin
      out_valid_r <= 1'b1;
    end else if (out_bus.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && res_valid) begin
      res_r <= res;
    end
  end

  assign out_bus.valid          = out_valid_r;
  assign out_bus.field_tag      = res_r.tag;
  assign out_bus.field_value    = $signed(res_r.value);
  assign out_bus.last_of_packet = res_r.last;
  assign out_bus.error_code     = res_r.err;

  // a new result only follows a transfer into the parse stage
  a_res_from_take: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(take))
    else $error("result appeared without a parsed byte");

  // errors are sticky
  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.halted |=> st_r.halted)
    else $error("halted flag cleared without reset");

  // every error result closes the packet
  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.err != ERR_NONE) |-> res_r.last)
    else $error("error result without last_of_packet");

  // the step never leaves the defined range
  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    take |=> (st_r.step <= ST_PL_DATA))
    else $error("parse step out of range");

endmodule

/* tb/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Feeds varint length-prefixed packets of every kind into the field parser,
// one byte per transfer, predicts each tagged field result and compares it
// field by field. Random idle bursts on both channels; the run closes with
// one sticky error, since only reset clears it.
// ----------------------------------------------------------------------------
module testbench;
  import vpfp_pkg::*;

  // configurations with no packet id behind them
  localparam logic [2:0] KIND_SPARE_LO = 3'd6;
  localparam logic [2:0] KIND_SPARE_HI = 3'd7;

  typedef logic [7:0] octet_q_t[$];

  // tracks the parse state, holds the expected fields and checks them
  class field_tracker;
    logic [2:0]   kind;
    parse_state_t st;
    result_t      expected_fields[$];
    int           mismatches;

    function new();
      kind = KIND_HANDSHAKE;
      st = '0;
      mismatches = 0;
    endfunction

    function void emit(logic [4:0] tag, logic [63:0] val, logic last, logic [2:0] err);
      expected_fields.push_back('{tag: tag, value: val, last: last, err: err});
    endfunction

    function void halt(logic [4:0] tag, logic [2:0] err);
      st.halted = 1'b1;
      emit(tag, '0, 1'b1, err);
    endfunction

    // field complete: move on to the next field or close the packet
    function void deliver(logic [4:0] tag, logic [63:0] val, logic [4:0] done_step);
      logic signed [63:0] decl_s;
      logic signed [63:0] used_s;
      logic [4:0]         nxt;
      case (done_step)
        ST_HS_VERSION:   nxt = ST_HS_ADDR_LEN;
        ST_HS_ADDR_BYTE: nxt = ST_HS_PORT;
        ST_HS_PORT:      nxt = ST_HS_NEXT;
        ST_CS_LOC_BYTE:  nxt = ST_CS_VIEW;
        ST_CS_VIEW:      nxt = ST_CS_CHAT;
        ST_CS_CHAT:      nxt = ST_CS_COLORS;
        ST_CS_COLORS:    nxt = ST_CS_SKIN;
        ST_CS_SKIN:      nxt = ST_CS_HAND;
        ST_CS_HAND:      nxt = ST_CS_FILTER;
        ST_PL_CHAN_BYTE: begin
          decl_s = {{32{st.decl_len[31]}}, st.decl_len};
          used_s = {32'd0, st.consumed};
          if (decl_s < used_s) begin
            halt(tag, ERR_LEN_SHORT);
            return;
          end
          nxt = (decl_s == used_s) ? ST_LENGTH : ST_PL_DATA;
        end
        default: nxt = ST_LENGTH;
      endcase
      st.step = nxt;
      emit(tag, val, nxt == ST_LENGTH, ERR_NONE);
    endfunction

    // one byte taken by the parser
    function void take_byte(logic [7:0] b);
      logic [4:0]         s;
      logic [31:0]        v;
      logic [63:0]        vx;
      logic [63:0]        wide;
      logic [31:0]        limit;
      logic               id_ok;
      logic [4:0]         first_step;
      logic signed [63:0] decl_s;
      logic signed [63:0] used_s;
      if (st.halted) return;
      if (st.step > ST_PL_DATA) st.step = ST_LENGTH;
      s = st.step;
      if (s != ST_LENGTH) st.consumed++;
      case (s)
        // varint fields, low group first
        ST_LENGTH, ST_ID, ST_HS_VERSION, ST_HS_ADDR_LEN, ST_HS_NEXT, ST_LOGIN_LEN,
        ST_CS_LOC_LEN, ST_CS_CHAT, ST_CS_HAND, ST_PL_CHAN_LEN: begin
          st.acc |= 64'(b[6:0]) << (7 * (st.byte_cnt & 4'd7));
          if (b[7]) begin
            if (st.byte_cnt >= VARINT_MAX_CONT) halt(s, ERR_VARINT_LONG);
            else st.byte_cnt++;
          end else begin
            v = st.acc[31:0];
            vx = {{32{v[31]}}, v};
            st.acc = '0;
            st.byte_cnt = '0;
            case (s)
              ST_LENGTH: begin
                st.decl_len = v;
                st.consumed = '0;
                st.step = ST_ID;
                emit(ST_LENGTH, vx, 1'b0, ERR_NONE);
              end
              ST_ID: begin
                id_ok = 1'b0;
                first_step = ST_LENGTH;
                case (kind)
                  KIND_HANDSHAKE: begin
                    id_ok = (v == ID_HANDSHAKE);
                    first_step = ST_HS_VERSION;
                  end
                  KIND_STATUS: id_ok = (v == ID_STATUS);
                  KIND_PING: begin
                    id_ok = (v == ID_PING);
                    first_step = ST_PING;
                  end
                  KIND_LOGIN: begin
                    id_ok = (v == ID_LOGIN);
                    first_step = ST_LOGIN_LEN;
                  end
                  KIND_SETTINGS: begin
                    id_ok = (v == ID_SETTINGS);
                    first_step = ST_CS_LOC_LEN;
                  end
                  KIND_PLUGIN: begin
                    id_ok = (v == ID_PLUGIN);
                    first_step = ST_PL_CHAN_LEN;
                  end
                  default: id_ok = 1'b0;
                endcase
                if (!id_ok) begin
                  halt(ST_ID, ERR_WRONG_ID);
                end else begin
                  st.step = first_step;
                  emit(ST_ID, vx, first_step == ST_LENGTH, ERR_NONE);
                end
              end
              // string length prefixes
              ST_HS_ADDR_LEN, ST_LOGIN_LEN, ST_CS_LOC_LEN, ST_PL_CHAN_LEN: begin
                limit = (s == ST_HS_ADDR_LEN) ? LIMIT_ADDR :
                        (s == ST_PL_CHAN_LEN) ? LIMIT_CHANNEL : LIMIT_NAME;
                if (v[31] || v > limit) begin
                  halt(s, ERR_BAD_STRLEN);
                end else begin
                  st.str_rem = v[14:0];
                  if (v == 0) begin
                    deliver(s, '0, s + 5'd1);
                  end else begin
                    st.step = s + 5'd1;
                    emit(s, vx, 1'b0, ERR_NONE);
                  end
                end
              end
              default: deliver(s, vx, s);
            endcase
          end
        end
        // string bytes
        ST_HS_ADDR_BYTE, ST_LOGIN_BYTE, ST_CS_LOC_BYTE, ST_PL_CHAN_BYTE: begin
          if (st.str_rem > 0) st.str_rem--;
          if (st.str_rem == 0) deliver(s, 64'(b), s);
          else emit(s, 64'(b), 1'b0, ERR_NONE);
        end
        // big-endian ushort and long
        ST_HS_PORT, ST_PING: begin
          st.acc = (st.acc << 8) | 64'(b);
          st.byte_cnt++;
          if (st.byte_cnt >= ((s == ST_HS_PORT) ? USHORT_BYTES : LONG_BYTES)) begin
            wide = st.acc;
            st.acc = '0;
            st.byte_cnt = '0;
            deliver(s, wide, s);
          end
        end
        ST_CS_VIEW, ST_CS_SKIN: deliver(s, 64'(b), s);
        ST_CS_COLORS, ST_CS_FILTER: deliver(s, (b != 8'd0) ? 64'd1 : 64'd0, s);
        // plugin data up to the declared length
        default: begin
          decl_s = {{32{st.decl_len[31]}}, st.decl_len};
          used_s = {32'd0, st.consumed};
          if (used_s >= decl_s) begin
            st.step = ST_LENGTH;
            emit(ST_PL_DATA, 64'(b), 1'b1, ERR_NONE);
          end else begin
            emit(ST_PL_DATA, 64'(b), 1'b0, ERR_NONE);
          end
        end
      endcase
    endfunction

    // compare one result transfer with the oldest expected field
    function void check_field(result_t got);
      result_t want;
      if (expected_fields.size() == 0) begin
        $error("unexpected result: tag %0d value %0h", got.tag, got.value);
        mismatches++;
        return;
      end
      want = expected_fields.pop_front();
      if (got.tag !== want.tag) begin
        $error("field_tag: expected %0d, actual %0d", want.tag, got.tag);
        mismatches++;
      end
      if (got.value !== want.value) begin
        $error("field_value: expected %0h, actual %0h", want.value, got.value);
        mismatches++;
      end
      if (got.last !== want.last) begin
        $error("last_of_packet: expected %0d, actual %0d", want.last, got.last);
        mismatches++;
      end
      if (got.err !== want.err) begin
        $error("error_code: expected %0d, actual %0d", want.err, got.err);
        mismatches++;
      end
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst_n;
  logic       cfg_wr_en;
  logic [2:0] cfg_wr_data;
  int         idle_pct;

  vpfp_in_if  in_bus();
  vpfp_out_if out_bus();

  field_tracker book = new();

  varint_packet_field_parser_core DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_bus      (in_bus),
    .out_bus     (out_bus),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always #1 clk = ~clk;

  // run limit
  initial begin
    #400000;
    $display("CHECKS FAILED");
    $finish;
  end

  // result sink with random stall bursts
  initial begin
    out_bus.ready = 1'b0;
    @(negedge clk);
    forever begin
      if ($urandom_range(1, 100) <= idle_pct) begin
        out_bus.ready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(negedge clk);
      end else begin
        out_bus.ready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(negedge clk);
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_bus.valid && out_bus.ready)
      book.check_field('{tag: out_bus.field_tag, value: out_bus.field_value,
                         last: out_bus.last_of_packet, err: out_bus.error_code});
  end

  function automatic logic [7:0] rand_octet();
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [31:0] rand_value();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 127);
      1: return $urandom_range(0, 16383);
      2: return $urandom;
      default: return $urandom_range(0, 3);
    endcase
  endfunction

  // extra continuation groups for non-minimal encodings
  function automatic int rand_pad();
    return ($urandom_range(0, 4) == 0) ? $urandom_range(1, 4) : 0;
  endfunction

  function automatic int rand_strlen(input int top);
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return top;
    if (r == 1) return 0;
    return $urandom_range(1, (top > 6) ? 6 : top);
  endfunction

  // varint encoding; a fifth group carries junk above bit 31
  function automatic void put_varint(ref octet_q_t q, input logic [31:0] v, input int pad);
    int         n;
    logic [7:0] b;
    n = 1;
    while (n < 5 && (v >> (7 * n)) != 0) n++;
    n = (n + pad > 5) ? 5 : n + pad;
    for (int i = 0; i < n; i++) begin
      b = 8'((v >> (7 * i)) & 32'h7F);
      if (i == 4) b[6:4] = 3'($urandom_range(0, 7));
      if (i < n - 1) b[7] = 1'b1;
      q.push_back(b);
    end
  endfunction

  // well-formed packet of one kind with random content
  function automatic void build_packet(input logic [2:0] kind, input int chan_len,
                                       ref octet_q_t q);
    octet_q_t    body;
    int          n;
    logic [31:0] decl;
    body = {};
    case (kind)
      KIND_HANDSHAKE: begin
        put_varint(body, ID_HANDSHAKE, rand_pad());
        put_varint(body, rand_value(), rand_pad());
        n = rand_strlen(LIMIT_ADDR);
        put_varint(body, n, rand_pad());
        repeat (n) body.push_back(rand_octet());
        repeat (2) body.push_back(rand_octet());
        put_varint(body, rand_value(), rand_pad());
      end
      KIND_STATUS: put_varint(body, ID_STATUS, rand_pad());
      KIND_PING: begin
        put_varint(body, ID_PING, rand_pad());
        repeat (8) body.push_back(rand_octet());
      end
      KIND_LOGIN: begin
        put_varint(body, ID_LOGIN, rand_pad());
        n = rand_strlen(LIMIT_NAME);
        put_varint(body, n, rand_pad());
        repeat (n) body.push_back(rand_octet());
      end
      KIND_SETTINGS: begin
        put_varint(body, ID_SETTINGS, rand_pad());
        n = rand_strlen(LIMIT_NAME);
        put_varint(body, n, rand_pad());
        repeat (n) body.push_back(rand_octet());
        body.push_back(rand_octet());
        put_varint(body, rand_value(), rand_pad());
        body.push_back(($urandom_range(0, 2) == 0) ? 8'd0 : rand_octet());
        body.push_back(rand_octet());
        put_varint(body, rand_value(), rand_pad());
        body.push_back(($urandom_range(0, 2) == 0) ? 8'd0 : rand_octet());
      end
      default: begin
        put_varint(body, ID_PLUGIN, rand_pad());
        n = (chan_len < 0) ? rand_strlen(12) : chan_len;
        put_varint(body, n, rand_pad());
        repeat (n) body.push_back(rand_octet());
        repeat ($urandom_range(0, 6)) body.push_back(rand_octet());
      end
    endcase
    decl = body.size();
    // the length is only checked for plugin packets
    if (kind != KIND_PLUGIN && $urandom_range(0, 3) == 0) decl = $urandom;
    put_varint(q, decl, rand_pad());
    foreach (body[i]) q.push_back(body[i]);
  endfunction

  // one byte transfer, after an optional idle burst
  task automatic send_byte(input logic [7:0] b);
    @(negedge clk);
    if ($urandom_range(1, 100) <= idle_pct) begin
      in_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end
    in_bus.valid <= 1'b1;
    in_bus.data_byte <= b;
    do @(posedge clk); while (!in_bus.ready);
    book.take_byte(b);
  endtask

  task automatic send_octets(input octet_q_t q);
    foreach (q[i]) send_byte(q[i]);
  endtask

  // drain the parser, then write the packet kind
  task automatic change_kind(input logic [2:0] k);
    @(negedge clk);
    in_bus.valid <= 1'b0;
    while (book.expected_fields.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= k;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    book.kind = k;
  endtask

  initial begin
    octet_q_t q;
    int       random_sent;
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    in_bus.valid = 1'b0;
    in_bus.data_byte = '0;
    idle_pct = 25;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: extremes of bytes and values, zero-length channel ending the packet
    change_kind(KIND_HANDSHAKE);
    send_octets({8'h0C, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h0F, 8'h01, 8'hFF,
                 8'hFF, 8'h00, 8'h7F});
    change_kind(KIND_STATUS);
    send_octets({8'h01, 8'h00});
    change_kind(KIND_PING);
    send_octets({8'h09, 8'h01, 8'h80, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01});
    change_kind(KIND_PLUGIN);
    send_octets({8'h02, 8'h0A, 8'h00});

    // random phases of well-formed packets
    random_sent = 0;
    while (random_sent < 500) begin
      change_kind(3'($urandom_range(KIND_HANDSHAKE, KIND_PLUGIN)));
      case ($urandom_range(0, 2))
        0: idle_pct = 0;
        1: idle_pct = 25;
        default: idle_pct = 50;
      endcase
      repeat ($urandom_range(1, 6)) begin
        q = {};
        build_packet(book.kind, -1, q);
        send_octets(q);
        random_sent += q.size();
      end
    end

    // last part without idling: one plugin packet, then one sticky error
    idle_pct = 0;
    change_kind(KIND_PLUGIN);
    q = {};
    build_packet(KIND_PLUGIN, -1, q);
    send_octets(q);
    q = {};
    case ($urandom_range(0, 6))
      0: q = {8'h80, 8'h81, 8'hFF, 8'h80, 8'h80};
      1: begin
        change_kind(3'($urandom_range(KIND_HANDSHAKE, KIND_PLUGIN)));
        q = {8'h01, 8'h7F};
      end
      2: begin
        change_kind(($urandom_range(0, 1) == 0) ? KIND_SPARE_LO : KIND_SPARE_HI);
        q = {8'h01, 8'h00};
      end
      3: begin
        change_kind(KIND_LOGIN);
        q = {8'h05, 8'h00};
        put_varint(q, ($urandom_range(0, 1) == 0) ? LIMIT_NAME + 1 : 32'hFFFF_FFFF, 0);
      end
      4: q = {8'h01, 8'h0A, 8'h03, rand_octet(), rand_octet(), rand_octet()};
      5: begin
        q = {8'h05, 8'h0A};
        put_varint(q, LIMIT_CHANNEL + 1, 0);
      end
      default: begin
        change_kind(KIND_HANDSHAKE);
        q = {8'h05, 8'h00, 8'h05};
        put_varint(q, LIMIT_ADDR + 1, 0);
      end
    endcase
    // bytes after the error give nothing
    repeat (3) q.push_back(rand_octet());
    send_octets(q);

    @(negedge clk);
    in_bus.valid <= 1'b0;
    while (book.expected_fields.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (book.mismatches == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule

/* filelist.f */
sv/vpfp_pkg.sv
sv/vpfp_if.sv
sv/vpfp_in_stage.sv
sv/vpfp_parse.sv
sv/varint_packet_field_parser_core.sv
tb/testbench.sv
